>>> design/eck_pkg.sv
// ----------------------------------------------------------------------------
// eck_pkg
// Shared types and constants for the expiring key cache.
// ----------------------------------------------------------------------------
package eck_pkg;

	localparam int CAP   = 1024;
	localparam int IDX_W = $clog2(CAP);
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int DW    = 32;

	// func codes
	localparam logic [2:0] FN_INSERT = 3'd0;
	localparam logic [2:0] FN_LOOKUP = 3'd1;
	localparam logic [2:0] FN_READ   = 3'd2;
	localparam logic [2:0] FN_REMOVE = 3'd3;
	localparam logic [2:0] FN_CLEAR  = 3'd4;
	localparam logic [2:0] FN_PURGE  = 3'd5;

	// register select, taken from paddr[2]
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_MAX     = 1'b1;

	typedef struct packed {
		logic          vld;
		logic [DW-1:0] key;
		logic [DW-1:0] tim;
		logic [DW-1:0] pay;
	} entry_t;

endpackage

>>> design/eck_cell.sv
// ----------------------------------------------------------------------------
// eck_cell
// One table slot of the ring; takes its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
module eck_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sh,
	input  logic           clr,
	input  eck_pkg::entry_t din,
	output eck_pkg::entry_t dout
);
	import eck_pkg::*;

	logic          vld_q;
	logic [DW-1:0] key_q;
	logic [DW-1:0] tim_q;
	logic [DW-1:0] pay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clr) begin
			vld_q <= 1'b0;
		end else if (sh) begin
			vld_q <= din.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (sh) begin
			key_q <= din.key;
			tim_q <= din.tim;
			pay_q <= din.pay;
		end
	end

	assign dout = '{vld: vld_q, key: key_q, tim: tim_q, pay: pay_q};

endmodule

>>> design/eck_chain.sv
// ----------------------------------------------------------------------------
// eck_chain
// Ring of slot cells: the head leaves at cell 0, the tail enters at the end.
// ----------------------------------------------------------------------------
module eck_chain (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           sh,
	input  logic           clr,
	input  eck_pkg::entry_t tail,
	output eck_pkg::entry_t head
);
	import eck_pkg::*;

	entry_t q [CAP];

	for (genvar j = 0; j < CAP; j++) begin : g_cell
		if (j == CAP - 1) begin : g_last
			eck_cell u_cell (
				.clk(clk), .arst_n(arst_n), .sh(sh), .clr(clr),
				.din(tail), .dout(q[j])
			);
		end else begin : g_mid
			eck_cell u_cell (
				.clk(clk), .arst_n(arst_n), .sh(sh), .clr(clr),
				.din(q[j+1]), .dout(q[j])
			);
		end
	end

	assign head = q[0];

endmodule

>>> design/expiring_key_cache_with_oldest_eviction.sv
// ----------------------------------------------------------------------------
// expiring_key_cache_with_oldest_eviction
// Keyed table with per-entry time stamps, freshness checks, stale purge and
// oldest-first eviction after inserts.
// ----------------------------------------------------------------------------
//
//   channel   signals                                   direction
//   -------   ---------------------------------------   ---------
//   command   start/busy, func, entry_key, entry_time,   in/out
//             entry_payload, now_time
//   result    done, found, fresh, out_time, out_payload, out
//             entry_count, removed_count
//   config    psel/penable/pwrite/paddr/pwdata/prdata    in/out
//
// The table is a ring of 1024 cells that rotates one slot per cycle while a
// pass runs; one full pass brings every slot past the head in slot order and
// leaves the ring aligned again. Lookup, read, remove and purge take one pass.
// Insert takes two passes, and one more pass per evicted entry. Clear and the
// unused codes take no pass. The pass length is set by the ring depth. Reset
// empties the table at once.
// The result sits for one cycle under done; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module expiring_key_cache_with_oldest_eviction (
	input  logic                      clk,
	input  logic                      arst_n,
	// config port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// command
	input  logic                      start,
	output logic                      busy,
	input  logic [2:0]                func,
	input  logic [eck_pkg::DW-1:0]    entry_key,
	input  logic [eck_pkg::DW-1:0]    entry_time,
	input  logic [eck_pkg::DW-1:0]    entry_payload,
	input  logic [eck_pkg::DW-1:0]    now_time,
	// result
	output logic                      done,
	output logic                      found,
	output logic                      fresh,
	output logic [eck_pkg::DW-1:0]    out_time,
	output logic [eck_pkg::DW-1:0]    out_payload,
	output logic [eck_pkg::CNT_W-1:0] entry_count,
	output logic [eck_pkg::CNT_W-1:0] removed_count
);
	import eck_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_WRITE, ST_EVICT, ST_CLEAR, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] timeout_q;
	logic [9:0]  max_q;

	// latched command
	logic [2:0]    func_q;
	logic [DW-1:0] key_q, time_q, pay_q, now_q;

	// pass bookkeeping
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q, removed_q;
	logic             found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [DW-1:0]    mt_q, mp_q;
	logic             free_ok_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [IDX_W-1:0] best_idx_q;
	logic             nb_ok_q;
	logic [IDX_W-1:0] nb_idx_q;
	logic [DW-1:0]    nb_time_q;

	entry_t head, tail;
	logic   sh, clr;
	logic   last, hit, stale, cleared, cand, wr_ok, ins_new;
	logic   nb_ok_n;
	logic [IDX_W-1:0] nb_idx_n, wr_idx;
	logic [DW-1:0]    nb_time_n;
	logic [CNT_W-1:0] cnt_dec, cnt_ins;
	logic [11:0]      max3;
	logic [9:0]       target;

	// ------------------------------------------------------------------
	// Config port: registers decoded on paddr[2], never inserts wait states.
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			REG_TIMEOUT: prdata = timeout_q;
			REG_MAX:     prdata = {22'd0, max_q};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 32'd30000;
			max_q     <= 10'd1000;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_TIMEOUT: timeout_q <= pwdata;
				REG_MAX:     max_q     <= pwdata[9:0];
				default:     ;
			endcase
		end
	end

	// eviction stops at floor(max * 3 / 4)
	assign max3   = {1'b0, max_q, 1'b0} + {2'b00, max_q};
	assign target = max3[11:2];

	// ------------------------------------------------------------------
	// Slot ring
	// ------------------------------------------------------------------
	assign sh  = (state_q == ST_SCAN) || (state_q == ST_WRITE) || (state_q == ST_EVICT);
	assign clr = (state_q == ST_CLEAR);

	eck_chain u_chain (
		.clk(clk), .arst_n(arst_n), .sh(sh), .clr(clr),
		.tail(tail), .head(head)
	);

	// ------------------------------------------------------------------
	// Head slot processing: modify the slot passing the head, send it on
	// ------------------------------------------------------------------
	assign last    = (idx_q == IDX_W'(CAP - 1));
	assign hit     = head.vld && (head.key == key_q) && (func_q <= FN_REMOVE);
	assign stale   = head.vld && ((now_q - head.tim) > timeout_q);
	assign wr_ok   = found_q || free_ok_q;
	assign wr_idx  = found_q ? match_idx_q : free_idx_q;
	assign ins_new = !found_q && free_ok_q;

	always_comb begin
		tail = head;
		unique case (state_q)
			ST_SCAN: begin
				if (func_q == FN_REMOVE && hit)
					tail.vld = 1'b0;
				if (func_q == FN_PURGE && stale)
					tail.vld = 1'b0;
			end
			ST_WRITE: begin
				if (wr_ok && idx_q == wr_idx) begin
					tail.vld = 1'b1;
					tail.key = key_q;
					tail.tim = time_q;
					tail.pay = pay_q;
				end
			end
			ST_EVICT: begin
				if (idx_q == best_idx_q)
					tail.vld = 1'b0;
			end
			default: ;
		endcase
	end

	assign cleared = head.vld && !tail.vld;
	assign cnt_dec = cleared ? count_q - CNT_W'(1) : count_q;
	assign cnt_ins = count_q + CNT_W'(ins_new);

	// oldest-entry tracking over the slots leaving the head; strict less-than
	// keeps the lowest slot on equal times
	assign cand = tail.vld && (idx_q == '0 || !nb_ok_q || tail.tim < nb_time_q);

	always_comb begin
		nb_ok_n   = cand || (idx_q != '0 && nb_ok_q);
		nb_idx_n  = cand ? idx_q : nb_idx_q;
		nb_time_n = cand ? tail.tim : nb_time_q;
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			func_q      <= '0;
			key_q       <= '0;
			time_q      <= '0;
			pay_q       <= '0;
			now_q       <= '0;
			idx_q       <= '0;
			count_q     <= '0;
			removed_q   <= '0;
			found_q     <= 1'b0;
			match_idx_q <= '0;
			mt_q        <= '0;
			mp_q        <= '0;
			free_ok_q   <= 1'b0;
			free_idx_q  <= '0;
			best_idx_q  <= '0;
			nb_ok_q     <= 1'b0;
			nb_idx_q    <= '0;
			nb_time_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q    <= func;
						key_q     <= entry_key;
						time_q    <= entry_time;
						pay_q     <= entry_payload;
						now_q     <= now_time;
						idx_q     <= '0;
						removed_q <= '0;
						found_q   <= 1'b0;
						free_ok_q <= 1'b0;
						case (func) inside
							FN_INSERT, FN_LOOKUP, FN_READ, FN_REMOVE, FN_PURGE:
								state_q <= ST_SCAN;
							FN_CLEAR: state_q <= ST_CLEAR;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					idx_q <= last ? '0 : idx_q + IDX_W'(1);
					if (hit) begin
						found_q     <= 1'b1;
						match_idx_q <= idx_q;
						mt_q        <= head.tim;
						mp_q        <= head.pay;
					end
					if (!head.vld && !free_ok_q) begin
						free_ok_q  <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (cleared) begin
						count_q   <= cnt_dec;
						removed_q <= removed_q + CNT_W'(1);
					end
					if (last)
						state_q <= (func_q == FN_INSERT) ? ST_WRITE : ST_DONE;
				end
				ST_WRITE: begin
					idx_q     <= last ? '0 : idx_q + IDX_W'(1);
					nb_ok_q   <= nb_ok_n;
					nb_idx_q  <= nb_idx_n;
					nb_time_q <= nb_time_n;
					if (last) begin
						count_q    <= cnt_ins;
						best_idx_q <= nb_idx_n;
						if (cnt_ins > {1'b0, max_q} && nb_ok_n)
							state_q <= ST_EVICT;
						else
							state_q <= ST_DONE;
					end
				end
				ST_EVICT: begin
					idx_q     <= last ? '0 : idx_q + IDX_W'(1);
					nb_ok_q   <= nb_ok_n;
					nb_idx_q  <= nb_idx_n;
					nb_time_q <= nb_time_n;
					if (cleared) begin
						count_q   <= cnt_dec;
						removed_q <= removed_q + CNT_W'(1);
					end
					if (last) begin
						best_idx_q <= nb_idx_n;
						if (cnt_dec > {1'b0, target} && nb_ok_n)
							state_q <= ST_EVICT;
						else
							state_q <= ST_DONE;
					end
				end
				ST_CLEAR: begin
					removed_q <= count_q;
					count_q   <= '0;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result
	// ------------------------------------------------------------------
	assign busy          = (state_q != ST_IDLE);
	assign done          = (state_q == ST_DONE);
	assign found         = found_q;
	assign fresh         = (func_q == FN_LOOKUP) && found_q && ((now_q - mt_q) < timeout_q);
	assign out_time      = (func_q == FN_READ && found_q) ? mt_q : '0;
	assign out_payload   = (func_q == FN_READ && found_q) ? mp_q : '0;
	assign entry_count   = count_q;
	assign removed_count = removed_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_done_before_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_count <= CNT_W'(CAP)))
		else $error("entry count beyond capacity");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_removed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && func_q != FN_CLEAR) |-> (removed_count <= CNT_W'(CAP)))
		else $error("removed count beyond capacity");

endmodule

>>> sim/expiring_key_cache_with_oldest_eviction_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiring_key_cache_with_oldest_eviction_tb
// Self-checking bench for the expiring key cache. A directed table covers the
// empty table, field extremes, overwrite, freshness and purge edges and the
// unused codes; random phases under several register settings then exercise
// eviction, purge and clear, all checked against a cycle-free cache model.
// ----------------------------------------------------------------------------
module expiring_key_cache_with_oldest_eviction_tb;
	import eck_pkg::*;

	localparam int CYCLE_LIMIT = 20_000_000;
	localparam int MAX_SHOWN   = 10;
	localparam int KEY_POOL    = 24;
	localparam logic [2:0] FN_NOP6 = 3'd6;
	localparam logic [2:0] FN_NOP7 = 3'd7;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] key;
		logic [31:0] tim;
		logic [31:0] pay;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		logic        found;
		logic        fresh;
		logic [31:0] tim;
		logic [31:0] pay;
		logic [10:0] count;
		logic [10:0] removed;
	} answer_t;

	typedef struct packed {
		cmd_t    cmd;
		logic    typed;
		answer_t ans;
	} row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic start, busy, done;
	logic [2:0] func;
	logic [31:0] entry_key, entry_time, entry_payload, now_time;
	logic found, fresh;
	logic [31:0] out_time, out_payload;
	logic [10:0] entry_count, removed_count;

	expiring_key_cache_with_oldest_eviction u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .func(func), .entry_key(entry_key),
		.entry_time(entry_time), .entry_payload(entry_payload), .now_time(now_time),
		.done(done), .found(found), .fresh(fresh), .out_time(out_time),
		.out_payload(out_payload), .entry_count(entry_count),
		.removed_count(removed_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cache image kept by the bench: slot contents, valid map, count, registers.
	logic [31:0] tbl_key [CAP];
	logic [31:0] tbl_time[CAP];
	logic [31:0] tbl_pay [CAP];
	logic        tbl_vld [CAP];
	int unsigned tbl_count;
	logic [31:0] cfg_timeout;
	logic [9:0]  cfg_max;

	answer_t pending_answers[$];
	int      mismatches;
	int      cycles;
	logic [31:0] key_pool[KEY_POOL];
	logic [31:0] clock_base;
	bit      no_idle;

	// Remove oldest entries (lowest slot on ties) down to 3/4 of the limit.
	function automatic int unsigned evict_oldest();
		int unsigned target, gone;
		int best;
		target = (int'(cfg_max) * 3) / 4;
		gone   = 0;
		if (tbl_count <= cfg_max)
			return 0;
		while (tbl_count > target) begin
			best = -1;
			for (int i = 0; i < CAP; i++)
				if (tbl_vld[i] && (best < 0 || tbl_time[i] < tbl_time[best]))
					best = i;
			if (best < 0)
				break;
			tbl_vld[best] = 1'b0;
			tbl_count--;
			gone++;
		end
		return gone;
	endfunction

	// Apply one command to the cache image and return what the block must answer.
	function automatic answer_t cache_apply(cmd_t c);
		answer_t a;
		int slot;
		logic [31:0] age;
		a    = '0;
		slot = -1;
		if (c.op <= FN_REMOVE) begin
			for (int i = 0; i < CAP; i++)
				if (slot < 0 && tbl_vld[i] && tbl_key[i] == c.key)
					slot = i;
			a.found = (slot >= 0);
		end
		case (c.op)
			FN_INSERT: begin
				if (slot < 0) begin
					for (int i = 0; i < CAP; i++)
						if (slot < 0 && !tbl_vld[i])
							slot = i;
					if (slot >= 0) begin
						tbl_vld[slot] = 1'b1;
						tbl_key[slot] = c.key;
						tbl_count++;
					end
				end
				if (slot >= 0) begin
					tbl_time[slot] = c.tim;
					tbl_pay[slot]  = c.pay;
				end
				a.removed = 11'(evict_oldest());
			end
			FN_LOOKUP: begin
				if (slot >= 0) begin
					age = c.now - tbl_time[slot];
					a.fresh = (age < cfg_timeout);
				end
			end
			FN_READ: begin
				if (slot >= 0) begin
					a.tim = tbl_time[slot];
					a.pay = tbl_pay[slot];
				end
			end
			FN_REMOVE: begin
				if (slot >= 0) begin
					tbl_vld[slot] = 1'b0;
					tbl_count--;
					a.removed = 11'd1;
				end
			end
			FN_CLEAR: begin
				a.removed = 11'(tbl_count);
				for (int i = 0; i < CAP; i++)
					tbl_vld[i] = 1'b0;
				tbl_count = 0;
			end
			FN_PURGE: begin
				for (int i = 0; i < CAP; i++) begin
					age = c.now - tbl_time[i];
					if (tbl_vld[i] && age > cfg_timeout) begin
						tbl_vld[i] = 1'b0;
						tbl_count--;
						a.removed++;
					end
				end
			end
			default: ;
		endcase
		a.count = 11'(tbl_count);
		return a;
	endfunction

	// Compare each result against the oldest pending answer.
	always @(posedge clk) begin
		answer_t want, got;
		if (arst_n && done) begin
			got = '{found, fresh, out_time, out_payload, entry_count, removed_count};
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result: %p", got);
			end else begin
				want = pending_answers.pop_front();
				if (got.found !== want.found || got.fresh !== want.fresh ||
				    got.tim !== want.tim || got.pay !== want.pay ||
				    got.count !== want.count || got.removed !== want.removed) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("result mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Watchdog: give up well beyond the slowest legal run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Idle the sender at random unless the current stretch runs flat out.
	task automatic sender_gap();
		while (!no_idle && $urandom_range(99) < 34) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Drive one item, hold it until accepted, then queue its answer.
	task automatic send_item(cmd_t c, logic typed, answer_t typed_ans);
		answer_t a;
		sender_gap();
		start         <= 1'b1;
		func          <= c.op;
		entry_key     <= c.key;
		entry_time    <= c.tim;
		entry_payload <= c.pay;
		now_time      <= c.now;
		do @(posedge clk); while (busy);
		a = cache_apply(c);
		pending_answers = {pending_answers, (typed ? typed_ans : a)};
	endtask

	// Drop start and wait until every answer has come and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic sel, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_TIMEOUT)
			cfg_timeout = value;
		else
			cfg_max = value[9:0];
	endtask

	function automatic cmd_t random_cmd();
		cmd_t c;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 36)       c.op = FN_INSERT;
		else if (pick < 56)  c.op = FN_LOOKUP;
		else if (pick < 71)  c.op = FN_READ;
		else if (pick < 82)  c.op = FN_REMOVE;
		else if (pick < 92)  c.op = FN_PURGE;
		else if (pick < 95)  c.op = FN_CLEAR;
		else if (pick < 97)  c.op = FN_NOP6;
		else if (pick < 99)  c.op = FN_NOP7;
		else                 c.op = 3'($urandom_range(7));
		// Mostly reuse a small key pool so hits, overwrites and removals happen.
		c.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL - 1)]
		                                  : $urandom;
		clock_base = clock_base + $urandom_range(0, 60);
		c.now = ($urandom_range(99) < 10) ? $urandom : clock_base;
		pick = $urandom_range(99);
		// Shared times make eviction ties likely.
		if (pick < 30)       c.tim = clock_base - $urandom_range(1);
		else if (pick < 80)  c.tim = clock_base - $urandom_range(0, 400);
		else                 c.tim = $urandom;
		c.pay = $urandom;
		return c;
	endfunction

	row_t directed[$];

	initial begin
		cmd_t c;
		cycles        = 0;
		mismatches    = 0;
		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		start         = 1'b0;
		func          = '0;
		entry_key     = '0;
		entry_time    = '0;
		entry_payload = '0;
		now_time      = '0;
		no_idle       = 1'b0;
		clock_base    = $urandom;
		cfg_timeout   = 32'd30000;
		cfg_max       = 10'd1000;
		tbl_count     = 0;
		for (int i = 0; i < CAP; i++)
			tbl_vld[i] = 1'b0;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < KEY_POOL; i++)
			key_pool[i] = $urandom;

		// Empty table after reset, extremes, overwrite, freshness edge at the
		// timeout, wrapped age, purge edge, unused codes, then a clear and a purge.
		directed = '{
			'{'{FN_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
			'{'{FN_READ, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
			'{'{FN_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
			'{'{FN_INSERT, 32'h0, 32'h0, 32'hFFFFFFFF, 32'h0}, 1'b1, '{0, 0, 0, 0, 1, 0}},
			'{'{FN_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF}, 1'b1,
			  '{0, 0, 0, 0, 2, 0}},
			'{'{FN_INSERT, 32'h0, 32'd5, 32'h1234, 32'h0}, 1'b1, '{1, 0, 0, 0, 2, 0}},
			'{'{FN_READ, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{1, 0, 5, 32'h1234, 2, 0}},
			'{'{FN_LOOKUP, 32'h0, 32'h0, 32'h0, 32'd30004}, 1'b1, '{1, 1, 0, 0, 2, 0}},
			'{'{FN_LOOKUP, 32'h0, 32'h0, 32'h0, 32'd30005}, 1'b1, '{1, 0, 0, 0, 2, 0}},
			'{'{FN_LOOKUP, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0}, 1'b1, '{1, 1, 0, 0, 2, 0}},
			'{'{FN_PURGE, 32'h0, 32'h0, 32'h0, 32'd30005}, 1'b1, '{0, 0, 0, 0, 1, 1}},
			'{'{FN_NOP6, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
			  '{0, 0, 0, 0, 1, 0}},
			'{'{FN_NOP7, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{0, 0, 0, 0, 1, 0}},
			'{'{FN_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{1, 0, 0, 0, 0, 1}},
			'{'{FN_INSERT, 32'hA5A5A5A5, 32'd100, 32'h5A5A5A5A, 32'd100}, 1'b0, '0},
			'{'{FN_INSERT, 32'h5A5A5A5A, 32'd100, 32'hA5A5A5A5, 32'd100}, 1'b0, '0},
			'{'{FN_INSERT, 32'h12345678, 32'd99, 32'h0, 32'd100}, 1'b0, '0},
			'{'{FN_READ, 32'h5A5A5A5A, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
			'{'{FN_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1, '{0, 0, 0, 0, 0, 3}},
			'{'{FN_PURGE, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF}, 1'b1, '{0, 0, 0, 0, 0, 0}}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].cmd, directed[i].typed, directed[i].ans);
		drain();

		// Random phases, each under its own register setting, extremes included.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin reg_write(REG_TIMEOUT, 32'd300);       reg_write(REG_MAX, 32'd8);    end
				1: begin reg_write(REG_TIMEOUT, 32'd0);         reg_write(REG_MAX, 32'd1);    end
				2: begin reg_write(REG_TIMEOUT, 32'hFFFFFFFF);  reg_write(REG_MAX, 32'd1023); end
				3: begin reg_write(REG_TIMEOUT, 32'd100);       reg_write(REG_MAX, 32'd5);    end
				default: begin
					reg_write(REG_TIMEOUT, $urandom_range(50, 5000));
					reg_write(REG_MAX, $urandom_range(2, 16));
				end
			endcase
			// Run the middle phase without any sender gaps.
			no_idle = (ph == 2);
			for (int n = 0; n < 100; n++) begin
				c = random_cmd();
				send_item(c, 1'b0, '0);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_answers.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
